// File: rtl/core/bhfdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhfdr_pkg
// Shared widths, the drain-entry record and the log10 table generator for the
// step-up FDR block.
// ----------------------------------------------------------------------------
package bhfdr_pkg;

  localparam int ROW_W = 32;
  localparam int VAL_W = 48;
  localparam int RAW_W = VAL_W + 1;

  localparam int DEF_MAX_ROWS      = 64;
  localparam int DEF_FRACTION_BITS = 24;

  // log10(2) in Q64
  localparam logic [63:0] LOG10_2_Q64 = 64'd5553023288523357132;

  // One entry handed to the output pipeline: a NaN echo or a drained row.
  typedef struct packed {
    logic             valid;
    logic             nan;
    logic             first;
    logic             last;
    logic [ROW_W-1:0] row;
    logic [VAL_W-1:0] val;
  } ld_t;

  // Per-cycle command for the sorting chain.
  typedef struct packed {
    logic ins;
    logic drain;
  } chain_ctl_t;

  // log10(k) with fb fraction bits, rounded half up. Elaboration-time only.
  function automatic logic [VAL_W-1:0] log10_fix(int unsigned k, int unsigned fb);
    logic [63:0]  m;
    logic [63:0]  frac;
    logic [63:0]  lg2;
    logic [127:0] sq;
    logic [127:0] pr;
    logic [63:0]  q60;
    logic [63:0]  rnd;
    int unsigned  e;
    e = 0;
    for (int i = 0; i < 6; i++) begin
      if ((k >> (e + 1)) != 0) e = e + 1;
    end
    m    = 64'(k) << (62 - e);
    frac = '0;
    // repeated squaring, one fraction bit of log2 per step
    for (int i = 1; i <= 60; i++) begin
      sq = {64'd0, m} * {64'd0, m};
      m  = sq[125:62];
      if (m[63]) begin
        m = m >> 1;
        frac[60 - i] = 1'b1;
      end
    end
    lg2 = (64'(e) << 60) | frac;
    pr  = {64'd0, lg2} * {64'd0, LOG10_2_Q64};
    q60 = pr[127:64];
    rnd = (q60 + (64'd1 << (59 - fb))) >> (60 - fb);
    return rnd[VAL_W-1:0];
  endfunction

endpackage

// File: rtl/core/bhfdr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhfdr_in_if / bhfdr_out_if
// Valid/ready channels for input rows and adjusted results.
// ----------------------------------------------------------------------------
interface bhfdr_in_if;
  logic                              valid;
  logic                              ready;
  logic [bhfdr_pkg::ROW_W-1:0]       in_row;
  logic signed [bhfdr_pkg::VAL_W-1:0] in_log10_p;
  logic                              in_is_nan;
  logic                              in_last;

  modport source(output valid, in_row, in_log10_p, in_is_nan, in_last, input ready);
  modport sink(input valid, in_row, in_log10_p, in_is_nan, in_last, output ready);
endinterface

interface bhfdr_out_if;
  logic                              valid;
  logic                              ready;
  logic [bhfdr_pkg::ROW_W-1:0]       out_row;
  logic signed [bhfdr_pkg::VAL_W-1:0] out_log10_fdr;
  logic                              out_is_nan;
  logic                              out_last;

  modport source(output valid, out_row, out_log10_fdr, out_is_nan, out_last, input ready);
  modport sink(input valid, out_row, out_log10_fdr, out_is_nan, out_last, output ready);
endinterface

// File: rtl/core/bhfdr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhfdr_cell
// One slot of the sorting chain. Insert shifts smaller-or-equal entries down
// one slot; drain shifts everything up one slot.
// ----------------------------------------------------------------------------
module bhfdr_cell (
  input  logic                          clk,
  input  bhfdr_pkg::chain_ctl_t         ctl,
  input  logic                          occ,
  input  logic [bhfdr_pkg::VAL_W-1:0]   p,
  input  logic [bhfdr_pkg::ROW_W-1:0]   p_row,
  input  logic                          hi_le,
  input  logic                          hi_gt,
  input  logic [bhfdr_pkg::VAL_W-1:0]   hi_val,
  input  logic [bhfdr_pkg::ROW_W-1:0]   hi_row,
  input  logic [bhfdr_pkg::VAL_W-1:0]   lo_val,
  input  logic [bhfdr_pkg::ROW_W-1:0]   lo_row,
  output logic                          le,
  output logic                          gt,
  output logic [bhfdr_pkg::VAL_W-1:0]   val,
  output logic [bhfdr_pkg::ROW_W-1:0]   row
);

  logic above;

  assign above = $signed(val) > $signed(p);
  assign le    = occ && !above;
  assign gt    = occ && above;

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (hi_le) begin
        val <= hi_val;
        row <= hi_row;
      end else if (!gt && hi_gt) begin
        // new value lands just below the first strictly larger entry
        val <= p;
        row <= p_row;
      end
    end else if (ctl.drain) begin
      val <= lo_val;
      row <= lo_row;
    end
  end

endmodule

// File: rtl/core/bhfdr_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhfdr_chain
// Row of sorting cells. Held entries sit right-justified, largest in the top
// cell, so a drain reads the top cell once per shift.
// ----------------------------------------------------------------------------
module bhfdr_chain #(
  parameter int MAX_ROWS = bhfdr_pkg::DEF_MAX_ROWS,
  localparam int CNT_W = $clog2(MAX_ROWS + 1)
) (
  input  logic                          clk,
  input  bhfdr_pkg::chain_ctl_t         ctl,
  input  logic [CNT_W-1:0]              count,
  input  logic [bhfdr_pkg::VAL_W-1:0]   p,
  input  logic [bhfdr_pkg::ROW_W-1:0]   p_row,
  output logic [bhfdr_pkg::VAL_W-1:0]   top_val,
  output logic [bhfdr_pkg::ROW_W-1:0]   top_row
);

  logic [bhfdr_pkg::VAL_W-1:0] val [MAX_ROWS];
  logic [bhfdr_pkg::ROW_W-1:0] row [MAX_ROWS];
  logic [MAX_ROWS-1:0]         le;
  logic [MAX_ROWS-1:0]         gt;

  for (genvar i = 0; i < MAX_ROWS; i++) begin : g_cell
    logic                        occ;
    logic                        hi_le;
    logic                        hi_gt;
    logic [bhfdr_pkg::VAL_W-1:0] hi_val;
    logic [bhfdr_pkg::ROW_W-1:0] hi_row;
    logic [bhfdr_pkg::VAL_W-1:0] lo_val;
    logic [bhfdr_pkg::ROW_W-1:0] lo_row;

    assign occ = count > CNT_W'(MAX_ROWS - 1 - i);

    if (i == MAX_ROWS - 1) begin : g_top
      assign hi_le  = 1'b0;
      assign hi_gt  = 1'b1;
      assign hi_val = '0;
      assign hi_row = '0;
    end else begin : g_mid
      assign hi_le  = le[i+1];
      assign hi_gt  = gt[i+1];
      assign hi_val = val[i+1];
      assign hi_row = row[i+1];
    end

    if (i == 0) begin : g_bot
      assign lo_val = '0;
      assign lo_row = '0;
    end else begin : g_up
      assign lo_val = val[i-1];
      assign lo_row = row[i-1];
    end

    bhfdr_cell u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .occ    (occ),
      .p      (p),
      .p_row  (p_row),
      .hi_le  (hi_le),
      .hi_gt  (hi_gt),
      .hi_val (hi_val),
      .hi_row (hi_row),
      .lo_val (lo_val),
      .lo_row (lo_row),
      .le     (le[i]),
      .gt     (gt[i]),
      .val    (val[i]),
      .row    (row[i])
    );
  end

  assign top_val = val[MAX_ROWS-1];
  assign top_row = row[MAX_ROWS-1];

endmodule

// File: rtl/core/bhfdr_adjust.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhfdr_adjust
// Two-stage output pipeline: adds the log10 rank terms, then applies the
// running minimum and holds the result for the output channel.
// ----------------------------------------------------------------------------
module bhfdr_adjust #(
  parameter int MAX_ROWS      = bhfdr_pkg::DEF_MAX_ROWS,
  parameter int FRACTION_BITS = bhfdr_pkg::DEF_FRACTION_BITS,
  localparam int CNT_W = $clog2(MAX_ROWS + 1),
  localparam int IDX_W = $clog2(MAX_ROWS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bhfdr_pkg::ld_t        ld,
  input  logic [CNT_W-1:0]      m_count,
  input  logic [CNT_W-1:0]      rank,
  output logic                  adv,
  bhfdr_out_if.source           results
);

  localparam int VW = bhfdr_pkg::VAL_W;
  localparam int RW = bhfdr_pkg::RAW_W;

  logic [VW-1:0]          log_tab [MAX_ROWS];
  logic [CNT_W-1:0]       m_m1;
  logic [CNT_W-1:0]       r_m1;
  logic [VW-1:0]          log_m;
  logic [VW-1:0]          log_r;
  logic signed [RW-1:0]   raw;

  logic                   s1_v;
  logic                   s1_nan;
  logic                   s1_first;
  logic                   s1_last;
  logic [bhfdr_pkg::ROW_W-1:0] s1_row;
  logic signed [RW-1:0]   s1_raw;

  logic signed [VW-1:0]   cm;
  logic signed [VW-1:0]   cm_prev;
  logic signed [VW-1:0]   cm_next;

  for (genvar k = 0; k < MAX_ROWS; k++) begin : g_log
    localparam logic [VW-1:0] LV = bhfdr_pkg::log10_fix(k + 1, FRACTION_BITS);
    assign log_tab[k] = LV;
  end

  assign m_m1  = m_count - CNT_W'(1);
  assign r_m1  = rank - CNT_W'(1);
  assign log_m = log_tab[m_m1[IDX_W-1:0]];
  assign log_r = log_tab[r_m1[IDX_W-1:0]];
  assign raw   = $signed({ld.val[VW-1], ld.val}) + $signed({1'b0, log_m})
               - $signed({1'b0, log_r});

  assign adv = !results.valid || results.ready;

  // minimum restarts at zero on the first drained row of a set
  assign cm_prev = s1_first ? '0 : cm;
  assign cm_next = (s1_raw < RW'(cm_prev)) ? s1_raw[VW-1:0] : cm_prev;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v          <= 1'b0;
      results.valid <= 1'b0;
    end else if (adv) begin
      s1_v          <= ld.valid;
      results.valid <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_nan   <= ld.nan;
      s1_first <= ld.first;
      s1_last  <= ld.last;
      s1_row   <= ld.row;
      s1_raw   <= raw;
      if (s1_v) begin
        results.out_row       <= s1_row;
        results.out_is_nan    <= s1_nan;
        results.out_last      <= s1_last;
        results.out_log10_fdr <= s1_nan ? '0 : cm_next;
        if (!s1_nan) cm <= cm_next;
      end
    end
  end

endmodule

// File: rtl/core/bh_fdr_step_up.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bh_fdr_step_up
// Benjamini-Hochberg step-up FDR adjustment of log10 p-values in fixed point.
//
//   channel   dir   handshake     payload
//   items     in    valid/ready   in_row, in_log10_p, in_is_nan, in_last
//   results   out   valid/ready   out_row, out_log10_fdr, out_is_nan, out_last
//
// A row is accepted while idle: finite rows are inserted into the sorting
// chain by one parallel compare-and-shift, NaN rows are echoed through the
// output pipeline. Closing a set starts a drain of m results, one shift of the
// chain per result, during which no rows are taken. Results pass the rank-term
// stage and the output register. Reset clears state, counters and valid flags
// only; the chain needs no clearing. A stalled output stalls drain and input.
// ----------------------------------------------------------------------------
module bh_fdr_step_up #(
  parameter int MAX_ROWS      = bhfdr_pkg::DEF_MAX_ROWS,
  parameter int FRACTION_BITS = bhfdr_pkg::DEF_FRACTION_BITS
) (
  input logic          clk,
  input logic          rst,
  bhfdr_in_if.sink     items,
  bhfdr_out_if.source  results
);

  localparam int CNT_W = $clog2(MAX_ROWS + 1);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic                        state;
  logic [CNT_W-1:0]            item_cnt;
  logic [CNT_W-1:0]            finite_cnt;
  logic [CNT_W-1:0]            m_count;
  logic [CNT_W-1:0]            rank;

  logic                        adv;
  logic                        acc;
  logic                        close;
  logic [CNT_W-1:0]            finite_upd;
  bhfdr_pkg::chain_ctl_t       ctl;
  bhfdr_pkg::ld_t              ld;
  logic [bhfdr_pkg::VAL_W-1:0] top_val;
  logic [bhfdr_pkg::ROW_W-1:0] top_row;

  assign items.ready = (state == ST_IDLE) && adv;
  assign acc         = items.valid && items.ready;
  // a full set closes even without the last marker
  assign close       = items.in_last || (item_cnt == CNT_W'(MAX_ROWS - 1));
  assign finite_upd  = finite_cnt + CNT_W'(!items.in_is_nan);

  assign ctl.ins   = acc && !items.in_is_nan;
  assign ctl.drain = (state == ST_DRAIN) && adv;

  always_comb begin
    if (state == ST_DRAIN) begin
      ld.valid = 1'b1;
      ld.nan   = 1'b0;
      ld.first = (rank == m_count);
      ld.last  = (rank == CNT_W'(1));
      ld.row   = top_row;
      ld.val   = top_val;
    end else begin
      ld.valid = acc && items.in_is_nan;
      ld.nan   = 1'b1;
      ld.first = 1'b0;
      ld.last  = close && (finite_cnt == '0);
      ld.row   = items.in_row;
      ld.val   = items.in_log10_p;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      item_cnt   <= '0;
      finite_cnt <= '0;
      m_count    <= '0;
      rank       <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (acc) begin
            item_cnt   <= close ? '0 : item_cnt + CNT_W'(1);
            finite_cnt <= close ? '0 : finite_upd;
            if (close && finite_upd != '0) begin
              state   <= ST_DRAIN;
              m_count <= finite_upd;
              rank    <= finite_upd;
            end
          end
        end
        ST_DRAIN: begin
          if (adv) begin
            rank <= rank - CNT_W'(1);
            if (rank == CNT_W'(1)) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  bhfdr_chain #(
    .MAX_ROWS (MAX_ROWS)
  ) u_chain (
    .clk     (clk),
    .ctl     (ctl),
    .count   (finite_cnt),
    .p       (items.in_log10_p),
    .p_row   (items.in_row),
    .top_val (top_val),
    .top_row (top_row)
  );

  bhfdr_adjust #(
    .MAX_ROWS      (MAX_ROWS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_adjust (
    .clk     (clk),
    .rst     (rst),
    .ld      (ld),
    .m_count (m_count),
    .rank    (rank),
    .adv     (adv),
    .results (results)
  );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the step-up FDR block: sets of tagged log10 p-values go in, and each
// accepted transaction is folded into a local sorted store; with a log10 table
// every NaN echo and every drained FDR is predicted and compared in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MAX_ROWS   = bhfdr_pkg::DEF_MAX_ROWS;
  localparam int FRAC_BITS  = bhfdr_pkg::DEF_FRACTION_BITS;
  localparam int VAL_BITS   = bhfdr_pkg::VAL_W;
  localparam int ROW_BITS   = bhfdr_pkg::ROW_W;
  localparam int CLK_HALF   = 4;
  localparam int CYCLE_CAP  = 400000;
  localparam int TAIL_CYCLES = 40;
  localparam longint ONE    = longint'(1) << FRAC_BITS;
  localparam logic signed [VAL_BITS-1:0] P_MAX = {1'b0, {(VAL_BITS-1){1'b1}}};
  localparam logic signed [VAL_BITS-1:0] P_MIN = {1'b1, {(VAL_BITS-1){1'b0}}};

  typedef struct {
    logic [ROW_BITS-1:0] row;
    logic [VAL_BITS-1:0] fdr;
    logic                nan;
    logic                last;
  } fdr_result_t;

  class fdr_scoreboard;
    longint              log10_tab[MAX_ROWS+1];
    longint              sorted_p[$];
    logic [ROW_BITS-1:0] sorted_tag[$];
    int                  set_items;
    fdr_result_t         expected_fdr[$];
    int                  errors;

    function new();
      for (int k = 1; k <= MAX_ROWS; k++) log10_tab[k] = log10_fixed(k);
      log10_tab[0] = 0;
      set_items = 0;
      errors = 0;
    endfunction

    // log2 by repeated squaring of a Q62 mantissa, scaled by log10(2) in Q64
    function automatic longint log10_fixed(int k);
      logic [63:0]  mant;
      logic [63:0]  lg2;
      logic [127:0] sq;
      logic [127:0] prod;
      logic [63:0]  q60;
      int           ex;
      ex = 0;
      while (ex < 6 && (k >> (ex + 1)) != 0) ex++;
      mant = 64'(k) << (62 - ex);
      lg2 = 64'(ex) << 60;
      for (int i = 1; i <= 60; i++) begin
        sq = {64'd0, mant} * {64'd0, mant};
        mant = sq[125:62];
        if (mant[63]) begin
          mant = mant >> 1;
          lg2[60 - i] = 1'b1;
        end
      end
      prod = {64'd0, lg2} * {64'd0, bhfdr_pkg::LOG10_2_Q64};
      q60 = prod[127:64];
      return longint'((q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS));
    endfunction

    function void note_row(logic [ROW_BITS-1:0] row, logic signed [VAL_BITS-1:0] p,
                           logic nan, logic last);
      fdr_result_t r;
      longint      pv;
      longint      raw;
      longint      run_min;
      int          pos;
      int          m;
      bit          close;
      pv = longint'(p);
      if (set_items >= MAX_ROWS) begin
        set_items = 0;
        sorted_p.delete();
        sorted_tag.delete();
      end
      set_items++;
      close = last || set_items >= MAX_ROWS;
      if (nan) begin
        r.row = row;
        r.fdr = '0;
        r.nan = 1'b1;
        r.last = close && sorted_p.size() == 0;
        expected_fdr.push_back(r);
      end else if (sorted_p.size() < MAX_ROWS) begin
        // equal values stay in arrival order
        pos = sorted_p.size();
        while (pos > 0 && sorted_p[pos-1] > pv) pos--;
        sorted_p.insert(pos, pv);
        sorted_tag.insert(pos, row);
      end
      if (close) begin
        m = sorted_p.size();
        run_min = 0;
        for (int j = m; j >= 1; j--) begin
          raw = sorted_p[j-1] + log10_tab[m] - log10_tab[j];
          if (raw < run_min) run_min = raw;
          r.row = sorted_tag[j-1];
          r.fdr = run_min[VAL_BITS-1:0];
          r.nan = 1'b0;
          r.last = (j == 1);
          expected_fdr.push_back(r);
        end
        sorted_p.delete();
        sorted_tag.delete();
        set_items = 0;
      end
    endfunction

    function void check_result(fdr_result_t got);
      fdr_result_t want;
      if (expected_fdr.size() == 0) begin
        errors++;
        $display("%0t: unexpected result row=%h fdr=%h nan=%b last=%b",
                 $time, got.row, got.fdr, got.nan, got.last);
        return;
      end
      want = expected_fdr.pop_front();
      if (got.row !== want.row || got.fdr !== want.fdr || got.nan !== want.nan ||
          got.last !== want.last) begin
        errors++;
        $display({"%0t: mismatch expected row=%h fdr=%h nan=%b last=%b,",
                  " got row=%h fdr=%h nan=%b last=%b"},
                 $time, want.row, want.fdr, want.nan, want.last,
                 got.row, got.fdr, got.nan, got.last);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycles;
  int   send_idle_pct;
  int   recv_stall_pct;
  logic signed [VAL_BITS-1:0] prev_p;

  bhfdr_in_if  items_ch();
  bhfdr_out_if results_ch();

  fdr_scoreboard sb = new();

  bh_fdr_step_up #(
    .MAX_ROWS(MAX_ROWS),
    .FRACTION_BITS(FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .items(items_ch),
    .results(results_ch)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    results_ch.ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    fdr_result_t got;
    if (!rst && results_ch.valid && results_ch.ready) begin
      got.row = results_ch.out_row;
      got.fdr = results_ch.out_log10_fdr;
      got.nan = results_ch.out_is_nan;
      got.last = results_ch.out_last;
      sb.check_result(got);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_row(logic [ROW_BITS-1:0] row, logic signed [VAL_BITS-1:0] p,
                          logic nan, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      items_ch.valid <= 1'b0;
      @(negedge clk);
    end
    items_ch.valid <= 1'b1;
    items_ch.in_row <= row;
    items_ch.in_log10_p <= p;
    items_ch.in_is_nan <= nan;
    items_ch.in_last <= last;
    do @(posedge clk); while (!items_ch.ready);
    sb.note_row(row, p, nan, last);
    prev_p = p;
    @(negedge clk);
  endtask

  function automatic logic signed [VAL_BITS-1:0] pick_p();
    longint v;
    case ($urandom_range(6))
      0: v = longint'({$urandom, $urandom});
      1: v = -longint'($urandom_range(40 * 256, 0)) * (ONE / 256);
      2: v = -longint'($urandom_range(ONE, 0));
      3: v = longint'($urandom_range(ONE, 0));
      4: v = longint'(prev_p);
      5: v = ($urandom_range(1)) ? longint'(P_MIN) : longint'(P_MAX);
      default: v = -longint'($urandom_range(8 * 16, 0)) * (ONE / 16);
    endcase
    return v[VAL_BITS-1:0];
  endfunction

  // a set of len rows; a full-size set may close by overflow alone
  task automatic send_set(int len, int nan_pct);
    logic last;
    for (int i = 0; i < len; i++) begin
      last = (i == len - 1) && (len < MAX_ROWS || $urandom_range(1));
      send_row($urandom, pick_p(), $urandom_range(99) < nan_pct, last);
    end
  endtask

  initial begin
    int phase_rows;
    clk = 1'b0;
    rst = 1'b1;
    cycles = 0;
    prev_p = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    items_ch.valid = 1'b0;
    items_ch.in_row = '0;
    items_ch.in_log10_p = '0;
    items_ch.in_is_nan = 1'b0;
    items_ch.in_last = 1'b0;
    results_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // single finite rows at the value extremes
    send_row('0, P_MAX, 1'b0, 1'b1);
    send_row('1, P_MIN, 1'b0, 1'b1);
    // lone NaN closing a set with no finite rows
    send_row(32'h5, VAL_BITS'(-ONE), 1'b1, 1'b1);
    // ties keep arrival order, NaN in the middle of the set
    send_row(32'h10, VAL_BITS'(-3 * ONE), 1'b0, 1'b0);
    send_row(32'h11, P_MAX, 1'b1, 1'b0);
    send_row(32'h12, VAL_BITS'(-3 * ONE), 1'b0, 1'b0);
    send_row(32'h13, VAL_BITS'(-ONE), 1'b0, 1'b0);
    send_row(32'h14, '0, 1'b0, 1'b1);
    // NaN closes the set: echo first, then the drain
    send_row(32'h20, VAL_BITS'(-2 * ONE), 1'b0, 1'b0);
    send_row(32'h21, VAL_BITS'(-5 * ONE), 1'b0, 1'b0);
    send_row(32'h22, P_MIN, 1'b1, 1'b1);
    // only NaNs
    send_row(32'hAAAA5555, '0, 1'b1, 1'b0);
    send_row(32'h5555AAAA, '1, 1'b1, 1'b1);
    // mixed extremes and one-LSB values
    send_row(32'h30, '0, 1'b0, 1'b0);
    send_row(32'h31, P_MAX, 1'b0, 1'b0);
    send_row(32'h32, VAL_BITS'(-1), 1'b0, 1'b0);
    send_row(32'h33, P_MIN, 1'b0, 1'b0);
    send_row(32'h34, VAL_BITS'(1), 1'b0, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      phase_rows = 0;
      if (phase == 1 || phase == 3) begin
        send_set(MAX_ROWS, 15);
        phase_rows += MAX_ROWS;
      end
      while (phase_rows < 75) begin
        int len;
        len = ($urandom_range(15) == 0) ? MAX_ROWS : $urandom_range(8, 1);
        send_set(len, ($urandom_range(9) == 0) ? 100 : 15);
        phase_rows += len;
      end
    end
    items_ch.valid <= 1'b0;

    while (sb.expected_fdr.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: bh_fdr_step_up.f
rtl/core/bhfdr_pkg.sv
rtl/core/bhfdr_if.sv
rtl/core/bhfdr_cell.sv
rtl/core/bhfdr_chain.sv
rtl/core/bhfdr_adjust.sv
rtl/core/bh_fdr_step_up.sv
tb/tb_top.sv
